// ===== hw/rtl/trpd_pkg.sv =====
// Shared types and constants of the TGA run-length pixel decoder.
// Used by trpd_ctrl, trpd_dpath and the top level; depends on nothing.
package trpd_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned AreaW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMirX   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMirY   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRle    = 3'd4;

  localparam logic [ByteW-1:0] LenMask   = 8'd127;
  localparam int unsigned      RepeatBit = 7;
  localparam logic [1:0]       LastPhase = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;  // restart image: position, pixel count, packet state
    logic take;  // a data byte is accepted this cycle
    logic step;  // advance position by one pixel
  } trpd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_we;     // a known register is written this cycle
    logic emits;      // the next byte completes a pixel
    logic finishes;   // that pixel's run ends the image
    logic multi;      // that run still needs more than one position step
    logic step_last;  // the final pending position step
    logic out_full;   // output register holds a record
  } trpd_stat_t;

endpackage

// ===== hw/rtl/trpd_ctrl.sv =====
// Controller of the TGA run-length pixel decoder: restart, byte accept and
// position stepping sequence. Depends on trpd_pkg.
module trpd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  input  trpd_pkg::trpd_stat_t stat_i,
  output trpd_pkg::trpd_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_ARM,
    S_LOAD,
    S_IDLE,
    S_STEP
  } state_e;

  state_e state_q, state_d;

  // the output register must be free only for a byte that completes a pixel
  assign in_stall_o = !(state_q == S_IDLE &&
                        (!stat_i.emits || !stat_i.out_full || !out_stall_i));

  always_comb begin
    cmd_o.take = in_valid_i && !in_stall_o;
    cmd_o.load = (state_q == S_LOAD) || (cmd_o.take && stat_i.emits && stat_i.finishes);
    cmd_o.step = (state_q == S_STEP);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_ARM:  state_d = S_LOAD;
      S_LOAD: state_d = S_IDLE;
      S_IDLE: begin
        if (cmd_o.take && stat_i.emits && !stat_i.finishes && stat_i.multi) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (stat_i.step_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_ARM;
    endcase
    // the pixel area is registered from the new size, so a write restarts through S_ARM before the load
    if (stat_i.cfg_we) begin
      state_d = S_ARM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ARM;
    end else begin
      state_q <= state_d;
    end
  end

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> state_q == S_IDLE)
    else $error("byte accepted outside idle");

  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && !stat_i.step_last && !stat_i.cfg_we) |=> state_q == S_STEP)
    else $error("position stepping cut short");

  a_load_after_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ARM && !stat_i.cfg_we) |=> state_q == S_LOAD)
    else $error("restart skipped the load");

endmodule

// ===== hw/rtl/trpd_dpath.sv =====
// Datapath of the TGA run-length pixel decoder: registers, pixel area,
// packet parsing, color assembly, position and output record.
// Depends on trpd_pkg.
module trpd_dpath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [trpd_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [trpd_pkg::CoordW-1:0]            cfg_data_i,
  input  logic [trpd_pkg::ByteW-1:0]             data_byte_i,
  input  logic                                   out_stall_i,
  input  trpd_pkg::trpd_cmd_t                    cmd_i,
  output trpd_pkg::trpd_stat_t                   stat_o,
  output logic                                   out_valid_o,
  output logic [trpd_pkg::CoordW-1:0]            start_x_o,
  output logic [trpd_pkg::CoordW-1:0]            start_y_o,
  output logic [trpd_pkg::ByteW-1:0]             run_length_o,
  output logic [trpd_pkg::ByteW-1:0]             red_o,
  output logic [trpd_pkg::ByteW-1:0]             green_o,
  output logic [trpd_pkg::ByteW-1:0]             blue_o,
  output logic [trpd_pkg::ByteW-1:0]             alpha_o,
  output logic                                   image_done_o
);

  localparam int unsigned CW = trpd_pkg::CoordW;
  localparam int unsigned BW = trpd_pkg::ByteW;
  localparam int unsigned AW = trpd_pkg::AreaW;

  // configuration
  logic [CW-1:0] width_q, height_q;
  logic          mir_x_q, mir_y_q, rle_q;
  logic [CW-1:0] eff_w, eff_h, w_m1, h_m1;
  logic [AW-1:0] area_q;

  // decode state
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [AW-1:0] left_q, left_d;
  logic          await_q, await_d, rep_q, rep_d;
  logic [BW-1:0] raw_left_q, raw_left_d, rep_len_q, rep_len_d;
  logic [1:0]    phase_q, phase_d;
  logic [3*BW-1:0] color_q, color_d;
  logic [BW-1:0] step_cnt_q, step_cnt_d;

  // combinational helpers
  logic          is_header;
  logic [BW-1:0] run_len, run_len_c, hdr_len;
  logic [CW-1:0] nx_col, nx_row, row_stepped;
  logic [CW:0]   col_inc;
  logic          finishes;

  // output register
  logic          out_valid_q;
  logic [CW-1:0] sx_q, sy_q;
  logic [BW-1:0] len_q, r_q, g_q, b_q, a_q;
  logic          done_q;

  always_comb begin
    eff_w = (width_q == '0) ? CW'(1) : width_q;
    eff_h = (height_q == '0) ? CW'(1) : height_q;
    w_m1  = eff_w - CW'(1);
    h_m1  = eff_h - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(1);
      height_q <= CW'(1);
      mir_x_q  <= 1'b0;
      mir_y_q  <= 1'b0;
      rle_q    <= 1'b0;
      area_q   <= AW'(1);
    end else begin
      area_q <= AW'(eff_w) * AW'(eff_h);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          trpd_pkg::RegWidth:  width_q  <= cfg_data_i;
          trpd_pkg::RegHeight: height_q <= cfg_data_i;
          trpd_pkg::RegMirX:   mir_x_q  <= cfg_data_i[0];
          trpd_pkg::RegMirY:   mir_y_q  <= cfg_data_i[0];
          trpd_pkg::RegRle:    rle_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // one-pixel step of the traversal position
  always_comb begin
    row_stepped = mir_y_q ? row_q - CW'(1) : row_q + CW'(1);
    col_inc     = {1'b0, col_q} + (CW+1)'(1);
    nx_row      = row_q;
    if (mir_x_q) begin
      if (col_q == '0) begin
        nx_col = w_m1;
        nx_row = row_stepped;
      end else begin
        nx_col = col_q - CW'(1);
      end
    end else if (col_inc >= {1'b0, eff_w}) begin
      nx_col = '0;
      nx_row = row_stepped;
    end else begin
      nx_col = col_inc[CW-1:0];
    end
  end

  always_comb begin
    is_header = rle_q && await_q;
    hdr_len   = (data_byte_i & trpd_pkg::LenMask) + BW'(1);
    run_len   = (rle_q && rep_q) ? rep_len_q : BW'(1);
    // a repeat run is clipped to the pixels left
    run_len_c = ({{(AW-BW){1'b0}}, run_len} > left_q) ? left_q[BW-1:0] : run_len;
    finishes  = (left_q == {{(AW-BW){1'b0}}, run_len_c});

    stat_o.cfg_we    = cfg_valid_i && (cfg_index_i == trpd_pkg::RegWidth ||
                       cfg_index_i == trpd_pkg::RegHeight ||
                       cfg_index_i == trpd_pkg::RegMirX ||
                       cfg_index_i == trpd_pkg::RegMirY ||
                       cfg_index_i == trpd_pkg::RegRle);
    stat_o.emits     = !is_header && (phase_q == trpd_pkg::LastPhase);
    stat_o.finishes  = finishes;
    stat_o.multi     = (run_len_c > BW'(1));
    stat_o.step_last = (step_cnt_q == BW'(1));
    stat_o.out_full  = out_valid_q;
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    left_d     = left_q;
    await_d    = await_q;
    rep_d      = rep_q;
    raw_left_d = raw_left_q;
    rep_len_d  = rep_len_q;
    phase_d    = phase_q;
    color_d    = color_q;
    step_cnt_d = step_cnt_q;

    if (cmd_i.load) begin
      col_d      = mir_x_q ? w_m1 : '0;
      row_d      = mir_y_q ? h_m1 : '0;
      left_d     = area_q;
      await_d    = 1'b1;
      rep_d      = 1'b0;
      raw_left_d = '0;
      rep_len_d  = '0;
      phase_d    = '0;
      color_d    = '0;
      step_cnt_d = '0;
    end else if (cmd_i.take) begin
      if (is_header) begin
        rep_d      = data_byte_i[trpd_pkg::RepeatBit];
        rep_len_d  = data_byte_i[trpd_pkg::RepeatBit] ? hdr_len : '0;
        raw_left_d = data_byte_i[trpd_pkg::RepeatBit] ? '0 : hdr_len;
        await_d    = 1'b0;
        phase_d    = '0;
      end else if (phase_q != trpd_pkg::LastPhase) begin
        case (phase_q)
          2'd0:    color_d[BW-1:0]      = data_byte_i;
          2'd1:    color_d[2*BW-1:BW]   = data_byte_i;
          default: color_d[3*BW-1:2*BW] = data_byte_i;
        endcase
        phase_d = phase_q + 2'd1;
      end else begin
        phase_d = '0;
        if (rle_q) begin
          if (rep_q) begin
            await_d   = 1'b1;
            rep_len_d = '0;
            rep_d     = 1'b0;
          end else begin
            if (raw_left_q != '0) begin
              raw_left_d = raw_left_q - BW'(1);
            end
            if (raw_left_q <= BW'(1)) begin
              await_d = 1'b1;
            end
          end
        end
        left_d     = left_q - {{(AW-BW){1'b0}}, run_len_c};
        col_d      = nx_col;
        row_d      = nx_row;
        step_cnt_d = run_len_c - BW'(1);
      end
    end else if (cmd_i.step) begin
      col_d      = nx_col;
      row_d      = nx_row;
      step_cnt_d = step_cnt_q - BW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= AW'(1);
      await_q    <= 1'b1;
      rep_q      <= 1'b0;
      raw_left_q <= '0;
      rep_len_q  <= '0;
      phase_q    <= '0;
      color_q    <= '0;
      step_cnt_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      left_q     <= left_d;
      await_q    <= await_d;
      rep_q      <= rep_d;
      raw_left_q <= raw_left_d;
      rep_len_q  <= rep_len_d;
      phase_q    <= phase_d;
      color_q    <= color_d;
      step_cnt_q <= step_cnt_d;
    end
  end

  // output record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.take && stat_o.emits) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && stat_o.emits) begin
      sx_q   <= col_q;
      sy_q   <= row_q;
      len_q  <= run_len_c;
      r_q    <= color_q[3*BW-1:2*BW];
      g_q    <= color_q[2*BW-1:BW];
      b_q    <= color_q[BW-1:0];
      a_q    <= data_byte_i;
      done_q <= finishes;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign start_x_o    = sx_q;
  assign start_y_o    = sy_q;
  assign run_length_o = len_q;
  assign red_o        = r_q;
  assign green_o      = g_q;
  assign blue_o       = b_q;
  assign alpha_o      = a_q;
  assign image_done_o = done_q;

  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q != '0)
    else $error("pixel count ran out without restart");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && stat_o.emits) |-> (!out_valid_q || !out_stall_i))
    else $error("pending record overwritten");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && stat_o.emits) |=> (len_q != '0 && len_q <= BW'(128)))
    else $error("run length out of range");

endmodule

// ===== hw/rtl/tga_rle_pixel_decoder_unit.sv =====
// Top level of the TGA run-length pixel decoder (32-bit BGRA pixel data).
// Depends on trpd_pkg, trpd_ctrl and trpd_dpath.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | in        | in_valid_i / in_stall_o  | data_byte_i
//   out     | out       | out_valid_o / out_stall_i| start_x/y, run_length, RGBA,
//           |           |                          | image_done
//   cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each byte is taken while the input is not stalled; a plain or raw-run pixel
// is four bytes. A repeat run of more than one pixel adds one-pixel position
// stepping in S_STEP, with the input stalled, unless it ends the image. A write
// to a known register restarts the image; the input stalls through S_ARM and
// S_LOAD after it (the pixel area passes through a registered multiplier).
// Reset does the same. A byte that completes a pixel waits while the output
// register is stalled; other bytes keep flowing.
module tga_rle_pixel_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [trpd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [trpd_pkg::CoordW-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [trpd_pkg::ByteW-1:0]       data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [trpd_pkg::CoordW-1:0]      start_x_o,
  output logic [trpd_pkg::CoordW-1:0]      start_y_o,
  output logic [trpd_pkg::ByteW-1:0]       run_length_o,
  output logic [trpd_pkg::ByteW-1:0]       red_o,
  output logic [trpd_pkg::ByteW-1:0]       green_o,
  output logic [trpd_pkg::ByteW-1:0]       blue_o,
  output logic [trpd_pkg::ByteW-1:0]       alpha_o,
  output logic                             image_done_o
);

  trpd_pkg::trpd_cmd_t  cmd;
  trpd_pkg::trpd_stat_t stat;

  assign cfg_ready_o = 1'b1;

  trpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  trpd_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .data_byte_i  (data_byte_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .start_x_o    (start_x_o),
    .start_y_o    (start_y_o),
    .run_length_o (run_length_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .image_done_o (image_done_o)
  );

endmodule

// ===== sim/tb_tga_rle_pixel_decoder_unit.sv =====
// Testbench for tga_rle_pixel_decoder_unit: BGRA byte streams, plain and packetized, checked
// run by run against a pixel-walk predictor held in a small scoreboard class.
// Depends on trpd_pkg and the RTL of the decoder; needs no files or arguments.
module tb_tga_rle_pixel_decoder_unit;
  import trpd_pkg::*;

  localparam int unsigned RandomBytes    = 550;
  localparam int unsigned SettleCycles   = 160;    // longest repeat-run stepping plus restart
  localparam int unsigned CycleLimit     = 600000;
  localparam int unsigned PressureAt     = 40;     // runs seen before the long output hold
  localparam int unsigned PressureCycles = 400;
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd6;  // index with no register behind it

  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ByteW-1:0]  len;
    logic [ByteW-1:0]  r;
    logic [ByteW-1:0]  g;
    logic [ByteW-1:0]  b;
    logic [ByteW-1:0]  a;
    logic              done;
  } pixel_run_t;

  class run_tracker;
    logic [CoordW-1:0] width_q;
    logic [CoordW-1:0] height_q;
    logic              mir_x;
    logic              mir_y;
    logic              rle_on;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [AreaW-1:0]  px_left;
    logic              want_hdr;
    logic              rep_run;
    logic [ByteW-1:0]  raw_cnt;
    logic [ByteW-1:0]  rep_cnt;
    logic [1:0]        phase;
    logic [23:0]       bgr;
    pixel_run_t        pending_runs[$];
    int unsigned       bytes_taken;
    int unsigned       runs_seen;
    int unsigned       images_seen;
    int unsigned       errors;

    function new();
      width_q  = 1;
      height_q = 1;
      mir_x    = 0;
      mir_y    = 0;
      rle_on   = 0;
      bytes_taken = 0;
      runs_seen   = 0;
      images_seen = 0;
      errors      = 0;
      restart();
    endfunction

    // a zero size register counts as one
    function logic [CoordW-1:0] eff_w();
      return (width_q == '0) ? CoordW'(1) : width_q;
    endfunction

    function logic [CoordW-1:0] eff_h();
      return (height_q == '0) ? CoordW'(1) : height_q;
    endfunction

    function void restart();
      col      = mir_x ? eff_w() - 1'b1 : '0;
      row      = mir_y ? eff_h() - 1'b1 : '0;
      px_left  = AreaW'(eff_w()) * AreaW'(eff_h());
      want_hdr = 1'b1;
      rep_run  = 1'b0;
      raw_cnt  = '0;
      rep_cnt  = '0;
      phase    = '0;
      bgr      = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
      case (idx)
        RegWidth:  width_q  = data;
        RegHeight: height_q = data;
        RegMirX:   mir_x    = data[0];
        RegMirY:   mir_y    = data[0];
        RegRle:    rle_on   = data[0];
        default:   return;
      endcase
      restart();
    endfunction

    function void next_row();
      row = mir_y ? row - 1'b1 : row + 1'b1;
    endfunction

    function void next_pixel();
      if (mir_x) begin
        if (col == '0) begin
          col = eff_w() - 1'b1;
          next_row();
        end else begin
          col = col - 1'b1;
        end
      end else begin
        col = col + 1'b1;
        if (col >= eff_w()) begin
          col = '0;
          next_row();
        end
      end
    endfunction

    // queue one run record; a run is clipped at the image end, which re-arms
    function void emit(int unsigned len, logic [ByteW-1:0] alpha);
      pixel_run_t  rec;
      int unsigned n;
      n = len;
      if (n > px_left) n = px_left;
      rec.x   = col;
      rec.y   = row;
      rec.len = n[ByteW-1:0];
      rec.r   = bgr[23:16];
      rec.g   = bgr[15:8];
      rec.b   = bgr[7:0];
      rec.a   = alpha;
      px_left = px_left - n;
      if (px_left == '0) begin
        rec.done = 1'b1;
        restart();
      end else begin
        rec.done = 1'b0;
        for (int unsigned i = 0; i < n; i++) next_pixel();
      end
      pending_runs.push_back(rec);
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      int unsigned len;
      bytes_taken++;
      if (rle_on && want_hdr) begin
        len = int'(b & LenMask) + 1;
        if (b[RepeatBit]) begin
          rep_run = 1'b1;
          rep_cnt = len[ByteW-1:0];
          raw_cnt = '0;
        end else begin
          rep_run = 1'b0;
          raw_cnt = len[ByteW-1:0];
          rep_cnt = '0;
        end
        want_hdr = 1'b0;
        phase    = '0;
        return;
      end
      if (phase != LastPhase) begin
        bgr[8*phase +: 8] = b;
        phase = phase + 1'b1;
        return;
      end
      phase = '0;
      if (!rle_on) begin
        emit(1, b);
        return;
      end
      if (rep_run) begin
        len      = rep_cnt;
        want_hdr = 1'b1;
        rep_cnt  = '0;
        rep_run  = 1'b0;
        emit(len, b);
        return;
      end
      if (raw_cnt != '0) raw_cnt = raw_cnt - 1'b1;
      if (raw_cnt == '0) want_hdr = 1'b1;
      emit(1, b);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_run(pixel_run_t got);
      pixel_run_t want;
      runs_seen++;
      if (got.done === 1'b1) images_seen++;
      if (pending_runs.size() == 0) begin
        $error("run at (%0d,%0d) len %0d with nothing pending", got.x, got.y, got.len);
        errors++;
        return;
      end
      want = pending_runs.pop_front();
      compare("start_x", want.x, got.x);
      compare("start_y", want.y, got.y);
      compare("run_length", want.len, got.len);
      compare("red", want.r, got.r);
      compare("green", want.g, got.g);
      compare("blue", want.b, got.b);
      compare("alpha", want.a, got.a);
      compare("image_done", want.done, got.done);
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0]  cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               out_stall_i = 1'b0;
  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [CoordW-1:0]  start_x_o;
  logic [CoordW-1:0]  start_y_o;
  logic [ByteW-1:0]   run_length_o;
  logic [ByteW-1:0]   red_o;
  logic [ByteW-1:0]   green_o;
  logic [ByteW-1:0]   blue_o;
  logic [ByteW-1:0]   alpha_o;
  logic               image_done_o;

  run_tracker  tracker = new();
  int unsigned cycles  = 0;
  int unsigned burst_left = 0;
  int unsigned phases  = 0;
  bit          hold_done = 1'b0;

  tga_rle_pixel_decoder_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .start_x_o    (start_x_o),
    .start_y_o    (start_y_o),
    .run_length_o (run_length_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .image_done_o (image_done_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // output side: checks every accepted beat, stalls at random, holds once for a long stretch
  initial begin : result_side
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned hold_left;
    int          r;
    logic        stall_nx;
    pixel_run_t  got;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.x    = start_x_o;
        got.y    = start_y_o;
        got.len  = run_length_o;
        got.r    = red_o;
        got.g    = green_o;
        got.b    = blue_o;
        got.a    = alpha_o;
        got.done = image_done_o;
        tracker.check_run(got);
      end
      if (!hold_done && tracker.runs_seen >= PressureAt) begin
        hold_done = 1'b1;
        hold_left = PressureCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_nx = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        stall_nx = 1'b1;
      end else if (free_left != 0) begin
        free_left--;
        stall_nx = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        stall_nx = 1'b1;
        if (r < 40) begin
          stall_nx = 1'b0;
        end else if (r < 70) begin
          stall_left = $urandom_range(0, 2);
        end else if (r < 82) begin
          stall_left = $urandom_range(4, 14);
        end else if (r < 85) begin
          stall_left = $urandom_range(30, 60);
        end else begin
          stall_nx  = 1'b0;
          free_left = $urandom_range(20, 60);
        end
      end
      out_stall_i <= stall_nx;
    end
  end

  function automatic int unsigned pick_gap();
    int r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    if (r < 96) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ByteW-1:0] color_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ByteW'($urandom());
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_byte(b);
  endtask

  task automatic send_pixel();
    repeat (4) send_byte(color_byte());
  endtask

  // leaves cfg_valid_i high; the caller lowers it after the last write of a batch
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  // all runs in, then time for trailing position stepping before the next write
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending_runs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 28) return CoordW'(1);
    return CoordW'($urandom_range(2, 6));
  endfunction

  // single-bit registers get junk in the upper data bits
  function automatic logic [CoordW-1:0] flag_data(input logic bit_val);
    logic [CoordW-1:0] d;
    d    = CoordW'($urandom());
    d[0] = bit_val;
    return d;
  endfunction

  task automatic random_config();
    bit wrote;
    wrote = 1'b0;
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(RegWidth, pick_size());
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(RegHeight, pick_size());
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(RegMirX, flag_data(1'($urandom_range(0, 1))));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(RegMirY, flag_data(1'($urandom_range(0, 1))));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(RegRle, flag_data($urandom_range(0, 3) != 0));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 19) == 0) begin
      cfg_write(RegSpare, CoordW'($urandom()));
      wrote = 1'b1;
    end
    if (wrote) cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed packets; stray bytes and cut-short raw runs now and then
  task automatic send_stream(input int unsigned stop_at);
    int          r;
    logic        rep;
    logic [6:0]  len7;
    int unsigned npix;
    while (tracker.bytes_taken < stop_at) begin
      if (!tracker.rle_on) begin
        send_byte(color_byte());
      end else if ($urandom_range(0, 19) == 0) begin
        send_byte(ByteW'($urandom()));
      end else begin
        rep = 1'($urandom_range(0, 1));
        r   = $urandom_range(0, 99);
        if (r < 75) len7 = 7'($urandom_range(0, 7));
        else if (r < 92) len7 = 7'($urandom_range(8, 31));
        else len7 = rep ? 7'd127 : 7'($urandom_range(0, 127));
        send_byte({rep, len7});
        npix = rep ? 1 : ((len7 > 31) ? 3 : int'(len7) + 1);
        for (int unsigned i = 0; i < npix; i++) begin
          if ($urandom_range(0, 29) == 0) break;
          send_pixel();
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned stop_at;
    int unsigned chunk;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: 1x1 plain image, every pixel ends an image
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    settle();

    // zero width, mirrored rows; repeat of 4 clipped to the 3 pixels there are
    cfg_write(RegWidth, 16'd0);
    cfg_write(RegHeight, 16'd3);
    cfg_write(RegMirX, 16'd0);
    cfg_write(RegMirY, 16'hffff);
    cfg_write(RegRle, 16'd1);
    cfg_valid_i <= 1'b0;
    send_byte(8'h83);
    send_pixel();
    settle();

    // 3x2 mirrored in x; raw run of 3 cut short by a register write
    cfg_write(RegWidth, 16'd3);
    cfg_write(RegHeight, 16'd2);
    cfg_write(RegMirX, 16'd1);
    cfg_valid_i <= 1'b0;
    send_byte(8'h02);
    send_pixel();
    send_pixel();
    settle();
    cfg_write(RegMirY, 16'd0);
    cfg_valid_i <= 1'b0;
    send_byte(8'hff);
    send_pixel();
    settle();

    stop_at = tracker.bytes_taken + RandomBytes;
    while (tracker.bytes_taken < stop_at) begin
      random_config();
      chunk = $urandom_range(20, 70);
      if (tracker.bytes_taken + chunk > stop_at) chunk = stop_at - tracker.bytes_taken;
      send_stream(tracker.bytes_taken + chunk);
      settle();
      phases++;
    end

    $display("covered %0d bytes over %0d register phases, both modes, mirrored and zero sizes;",
             tracker.bytes_taken, phases);
    $display("%0d runs checked, %0d of them ending an image, %0d mismatches",
             tracker.runs_seen, tracker.images_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
